// ----- hw/rtl/dgt_pkg.sv -----
`default_nettype none

package dgt_pkg;

   localparam int DELTA_W = 16;
   localparam int TIME_W  = 53;
   localparam int SUM_W   = 32;
   localparam int STEP_W  = 16;
   localparam int COOL_W  = 32;
   localparam int PROD_W  = SUM_W + STEP_W;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam int REQ_TDATA_W = 88;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;

   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_MOTION  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HORIZONTAL_STEP = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTICAL_STEP   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN_NS     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOLLOW_DRAG     = 8'd3;

   localparam logic [STEP_W-1:0] HORIZONTAL_STEP_RESET = 16'd150;
   localparam logic [STEP_W-1:0] VERTICAL_STEP_RESET   = 16'd150;
   localparam logic [COOL_W-1:0] COOLDOWN_NS_RESET     = 32'd250000000;

   typedef enum logic [2:0] {
      ACT_NONE         = 3'd0,
      ACT_LEFT         = 3'd1,
      ACT_RIGHT        = 3'd2,
      ACT_OVERVIEW     = 3'd3,
      ACT_APP_OVERVIEW = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      AXIS_NONE       = 2'd0,
      AXIS_HORIZONTAL = 2'd1,
      AXIS_VERTICAL   = 2'd2
   } axis_type;

   typedef struct packed {
      logic [STEP_W-1:0] horizontal_step;
      logic [STEP_W-1:0] vertical_step;
      logic [COOL_W-1:0] cooldown_ns;
      logic              follow_drag;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic [TIME_W-1:0]         time_ns;
   } item_type;

   typedef struct packed {
      action_type action;
      logic       replay_click;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/dgt_csr.sv -----
`default_nettype none

module dgt_csr
   import dgt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HORIZONTAL_STEP: cfg_in.horizontal_step = csr_data[STEP_W-1:0];
            CSR_VERTICAL_STEP:   cfg_in.vertical_step   = csr_data[STEP_W-1:0];
            CSR_COOLDOWN_NS:     cfg_in.cooldown_ns     = csr_data[COOL_W-1:0];
            CSR_FOLLOW_DRAG:     cfg_in.follow_drag     = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.horizontal_step <= HORIZONTAL_STEP_RESET;
         cfg_ff.vertical_step   <= VERTICAL_STEP_RESET;
         cfg_ff.cooldown_ns     <= COOLDOWN_NS_RESET;
         cfg_ff.follow_drag     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/dgt_core.sv -----
`default_nettype none

module dgt_core
   import dgt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step_en,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output result_type    result
);

   logic                    held_ff, held_in;
   logic signed [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0] sum_y_ff, sum_y_in;
   axis_type                locked_ff, locked_in;
   logic                    fired_ff, fired_in;
   logic                    has_fire_ff, has_fire_in;
   logic [TIME_W-1:0]       last_fire_ff, last_fire_in;

   logic signed [SUM_W:0]   sx_wide, sy_wide;
   logic signed [SUM_W-1:0] sx, sy;
   logic [SUM_W-1:0]        ax, ay;
   logic [PROD_W-1:0]       prod_x, prod_y;
   logic                    ax_reaches, ay_reaches;
   axis_type                picked, axis;
   logic [TIME_W-1:0]       elapsed;
   logic                    in_cooldown;
   logic signed [SUM_W:0]   step_pos, step_neg, sx_ext, sx_rem;
   logic signed [SUM_W-1:0] sx_clamped;
   logic                    left;

   assign sx_wide = {sum_x_ff[SUM_W-1], sum_x_ff}
                  + {{(SUM_W+1-DELTA_W){item.delta_x[DELTA_W-1]}}, item.delta_x};
   assign sy_wide = {sum_y_ff[SUM_W-1], sum_y_ff}
                  + {{(SUM_W+1-DELTA_W){item.delta_y[DELTA_W-1]}}, item.delta_y};

   assign sx = (sx_wide[SUM_W] != sx_wide[SUM_W-1])
             ? (sx_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}})
             : sx_wide[SUM_W-1:0];
   assign sy = (sy_wide[SUM_W] != sy_wide[SUM_W-1])
             ? (sy_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}})
             : sy_wide[SUM_W-1:0];

   assign ax = sx[SUM_W-1] ? (~sx + 1'b1) : sx;
   assign ay = sy[SUM_W-1] ? (~sy + 1'b1) : sy;

   assign prod_x = PROD_W'(ax) * PROD_W'(cfg.vertical_step);
   assign prod_y = PROD_W'(ay) * PROD_W'(cfg.horizontal_step);

   assign ax_reaches = ax >= SUM_W'(cfg.horizontal_step);
   assign ay_reaches = ay >= SUM_W'(cfg.vertical_step);

   always_comb begin
      if (ax_reaches && (prod_x >= prod_y)) begin
         picked = AXIS_HORIZONTAL;
      end else if (ay_reaches) begin
         picked = AXIS_VERTICAL;
      end else begin
         picked = AXIS_NONE;
      end
   end

   assign axis = (locked_ff != AXIS_NONE) ? locked_ff : picked;

   assign elapsed     = item.time_ns - last_fire_ff;
   assign in_cooldown = has_fire_ff
                      && ((item.time_ns < last_fire_ff)
                          || (elapsed < TIME_W'(cfg.cooldown_ns)));

   assign step_pos = {{(SUM_W+1-STEP_W){1'b0}}, cfg.horizontal_step};
   assign step_neg = -step_pos;
   assign sx_ext   = {sx[SUM_W-1], sx};

   always_comb begin
      if (sx_ext > step_pos) begin
         sx_clamped = step_pos[SUM_W-1:0];
      end else if (sx_ext < step_neg) begin
         sx_clamped = step_neg[SUM_W-1:0];
      end else begin
         sx_clamped = sx;
      end
   end

   assign left   = sx[SUM_W-1];
   assign sx_rem = sx_ext + (left ? step_pos : step_neg);

   always_comb begin
      held_in      = held_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      locked_in    = locked_ff;
      fired_in     = fired_ff;
      has_fire_in  = has_fire_ff;
      last_fire_in = last_fire_ff;
      result.action       = ACT_NONE;
      result.replay_click = 1'b0;
      if (step_en) begin
         case (item.opcode)
            OP_PRESS: begin
               held_in     = 1'b1;
               sum_x_in    = '0;
               sum_y_in    = '0;
               locked_in   = AXIS_NONE;
               fired_in    = 1'b0;
               has_fire_in = 1'b0;
            end
            OP_RELEASE: begin
               if (held_ff) begin
                  held_in             = 1'b0;
                  result.replay_click = !fired_ff;
               end
            end
            OP_MOTION: begin
               if (held_ff) begin
                  sum_x_in = sx;
                  sum_y_in = sy;
                  if (axis == AXIS_VERTICAL) begin
                     locked_in = AXIS_VERTICAL;
                     if (!fired_ff) begin
                        fired_in      = 1'b1;
                        result.action = sy[SUM_W-1] ? ACT_OVERVIEW : ACT_APP_OVERVIEW;
                     end
                  end else if (axis == AXIS_HORIZONTAL) begin
                     locked_in = AXIS_HORIZONTAL;
                     if (in_cooldown) begin
                        sum_x_in = sx_clamped;
                     end else if (ax_reaches) begin
                        sum_x_in      = sx_rem[SUM_W-1:0];
                        last_fire_in  = item.time_ns;
                        has_fire_in   = 1'b1;
                        fired_in      = 1'b1;
                        result.action = (left ^ cfg.follow_drag) ? ACT_LEFT : ACT_RIGHT;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         locked_ff    <= AXIS_NONE;
         fired_ff     <= 1'b0;
         has_fire_ff  <= 1'b0;
         last_fire_ff <= '0;
      end else begin
         held_ff      <= held_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         locked_ff    <= locked_in;
         fired_ff     <= fired_in;
         has_fire_ff  <= has_fire_in;
         last_fire_ff <= last_fire_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/pointer_drag_gesture_tracker.sv -----
// Channel  Direction  Handshake                Contents
// req      in         req_tvalid / req_tready  one pointer event per beat
// rsp      out        rsp_tvalid / rsp_tready  one result per beat
// csr      in         csr_valid / csr_ready    register index and write data
//
// Every request beat yields exactly one response beat, via the input then the result register.
// One beat is accepted per cycle while rsp_tready holds; the two registers decouple the sides.
// A stalled response stops the step logic, and the input register then holds the next beat.
// Reset is synchronous and active high; it clears the handshake and gesture state.
// The configuration port is always ready, and a write takes effect on the next cycle.
`default_nettype none

module pointer_drag_gesture_tracker
   import dgt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [84:32] time_ns, [31:16] delta_y, [15:0] delta_x
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [3] replay_click, [2:0] action
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg;
   item_type   in_item_ff, in_item_in;
   logic       in_valid_ff, in_valid_in;
   result_type out_result_ff, out_result_in;
   logic       out_valid_ff, out_valid_in;
   result_type step_result;
   logic       step_en;
   logic       req_accept;

   dgt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dgt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign step_en    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_item_in.opcode  = req_tuser;
      in_item_in.delta_x = req_tdata[15:0];
      in_item_in.delta_y = req_tdata[31:16];
      in_item_in.time_ns = req_tdata[84:32];
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_result_in = step_result;
      if (step_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= in_item_in;
      end
      if (step_en) begin
         out_result_ff <= out_result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_result_ff.replay_click, out_result_ff.action};

endmodule

`default_nettype wire
